@@ hw/rtl/pce_pkg.sv @@
package pce_pkg;

  // Four segment coefficients, signed Q16.16
  typedef struct packed {
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
  } coef_set_t;

  // Request to the Horner unit
  typedef struct packed {
    logic               start;
    logic signed [32:0] d;
    coef_set_t          coef;
  } hrn_req_t;

  // Response from the Horner unit
  typedef struct packed {
    logic               done;
    logic               sat;
    logic signed [31:0] y;
  } hrn_rsp_t;

endpackage

@@ hw/rtl/piecewise_cubic_evaluator_unit.sv @@
// Piecewise cubic spline evaluator; one item in flight, held longer while a result waits.
// Load item: written to the table at acceptance, next item the cycle after, no result.
// Evaluate item, knots in use: scan at one knot read each scan cycle, fetch, start, Horner
// steps, then handoff of the result; the next item is taken once the handoff is done.
// Outside the knots the result follows the scan and fetch; with an empty table, at once.
// Reset (synchronous, rst_n low) clears control and knots_in_use; table is undefined.
module piecewise_cubic_evaluator_unit #(
  parameter int MAX_KNOTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_knot_x,
  input  logic signed [31:0] in_coef_const_in,
  input  logic signed [31:0] in_coef_linear_in,
  input  logic signed [31:0] in_coef_quad_in,
  input  logic signed [31:0] in_coef_cubic_in,
  input  logic signed [31:0] in_x_query,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_y_value,
  output logic [1:0]         out_status,
  output logic [5:0]         out_segment,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pce_pkg::*;

  localparam int DEPTH = (MAX_KNOTS < 64) ? MAX_KNOTS : 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic       FUNC_LOAD   = 1'b0;
  localparam logic       FUNC_EVAL   = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_EVAL_START,
    S_HORNER,
    S_DONE
  } state_t;

  // configuration register
  logic [6:0] knots_r;
  logic       cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = 32'(knots_r);

  // single register: every write lands on knots_in_use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knots_r <= 7'd0;
    end else if (cfg_wr && (paddr == 2'd0 || paddr != 2'd0)) begin
      knots_r <= pwdata[6:0];
    end
  end

  state_t             state_r, state_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      scan_idx_r, scan_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic               cmp_last_r, cmp_last_nxt;
  logic [AW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]      seg_r, seg_nxt;
  logic               below_r, below_nxt;
  logic               above_r, above_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic signed [31:0] res_y_r, res_y_nxt;
  logic [1:0]         res_st_r, res_st_nxt;
  logic [AW-1:0]      res_seg_r, res_seg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_y_r, out_y_nxt;
  logic [1:0]         out_st_r, out_st_nxt;
  logic [AW-1:0]      out_seg_r, out_seg_nxt;

  logic               in_acc;
  logic [CW-1:0]      n_eff;
  logic [AW-1:0]      seg_lim;
  logic [AW-1:0]      seg_use;
  logic               tbl_wr;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_knot;
  coef_set_t          rd_coef;
  coef_set_t          wr_coef;
  hrn_req_t           hrn_req;
  hrn_rsp_t           hrn_rsp;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // knots in use, clamped to the table depth
  assign n_eff = (knots_r > 7'(DEPTH)) ? CW'(DEPTH) : CW'(knots_r);

  // segment clamp: never past the second to last knot
  assign seg_lim = (n_r >= CW'(2)) ? AW'(n_r - CW'(2)) : '0;
  assign seg_use = (seg_r > seg_lim) ? seg_lim : seg_r;

  // table write on an accepted load item within the table
  assign tbl_wr     = in_acc && (in_func == FUNC_LOAD) && (7'(in_entry_index) < 7'(DEPTH));
  assign wr_coef.c0 = in_coef_const_in;
  assign wr_coef.c1 = in_coef_linear_in;
  assign wr_coef.c2 = in_coef_quad_in;
  assign wr_coef.c3 = in_coef_cubic_in;

  // read address: scan pointer, then the chosen segment
  assign rd_addr = (state_r == S_FETCH) ? seg_use : scan_idx_r[AW-1:0];

  pce_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (in_entry_index[AW-1:0]),
    .wr_knot (in_knot_x),
    .wr_coef (wr_coef),
    .rd_addr (rd_addr),
    .rd_knot (rd_knot),
    .rd_coef (rd_coef)
  );

  // Horner request from the fetched entry
  assign hrn_req.start = (state_r == S_EVAL_START);
  assign hrn_req.d     = 33'(x_r) - 33'(rd_knot);
  assign hrn_req.coef  = rd_coef;

  pce_horner u_horner (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hrn_req),
    .rsp   (hrn_rsp)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_last_nxt  = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    seg_nxt       = seg_r;
    below_nxt     = below_r;
    above_nxt     = above_r;
    x_nxt         = x_r;
    res_y_nxt     = res_y_r;
    res_st_nxt    = res_st_r;
    res_seg_nxt   = res_seg_r;
    out_valid_nxt = out_valid_r;
    out_y_nxt     = out_y_r;
    out_st_nxt    = out_st_r;
    out_seg_nxt   = out_seg_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_func == FUNC_EVAL)) begin
          n_nxt        = n_eff;
          x_nxt        = in_x_query;
          scan_idx_nxt = '0;
          seg_nxt      = '0;
          below_nxt    = 1'b0;
          above_nxt    = 1'b0;
          if (n_eff == '0) begin
            res_y_nxt   = '0;
            res_st_nxt  = ST_EMPTY;
            res_seg_nxt = '0;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue one knot read per cycle
        if (scan_idx_r < n_r) begin
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_idx_r[AW-1:0];
          cmp_last_nxt = (scan_idx_r == CW'(n_r - CW'(1)));
          scan_idx_nxt = scan_idx_r + CW'(1);
        end
        // compare the knot read last cycle
        if (cmp_vld_r) begin
          if (rd_knot <= x_r) begin
            seg_nxt = cmp_idx_r;
          end
          if (cmp_idx_r == '0 && x_r < rd_knot) begin
            below_nxt = 1'b1;
          end
          if (cmp_last_r) begin
            above_nxt = (x_r > rd_knot);
            state_nxt = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        // read address is seg_use this cycle
        seg_nxt = seg_use;
        if (below_r || above_r) begin
          res_y_nxt   = '0;
          res_st_nxt  = ST_RANGE;
          res_seg_nxt = '0;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_EVAL_START;
        end
      end

      S_EVAL_START: begin
        state_nxt = S_HORNER;
      end

      S_HORNER: begin
        if (hrn_rsp.done) begin
          res_y_nxt   = hrn_rsp.y;
          res_st_nxt  = hrn_rsp.sat ? ST_SAT : ST_OK;
          res_seg_nxt = seg_r;
          state_nxt   = S_DONE;
        end
      end

      S_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_y_nxt     = res_y_r;
          out_st_nxt    = res_st_r;
          out_seg_nxt   = res_seg_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      cmp_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      cmp_last_r  <= cmp_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    seg_r      <= seg_nxt;
    below_r    <= below_nxt;
    above_r    <= above_nxt;
    x_r        <= x_nxt;
    res_y_r    <= res_y_nxt;
    res_st_r   <= res_st_nxt;
    res_seg_r  <= res_seg_nxt;
    out_y_r    <= out_y_nxt;
    out_st_r   <= out_st_nxt;
    out_seg_r  <= out_seg_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_y_value = out_y_r;
  assign out_status  = out_st_r;
  assign out_segment = 6'(out_seg_r);

endmodule

@@ hw/rtl/pce_table.sv @@
module pce_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic signed [31:0]      wr_knot,
  input  pce_pkg::coef_set_t      wr_coef,
  input  logic [AW-1:0]           rd_addr,
  output logic signed [31:0]      rd_knot,
  output pce_pkg::coef_set_t      rd_coef
);
  import pce_pkg::*;

  logic signed [31:0] knot_mem [DEPTH];
  coef_set_t          coef_mem [DEPTH];

  // knot positions: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      knot_mem[wr_addr] <= wr_knot;
    end
    rd_knot <= knot_mem[rd_addr];
  end

  // segment coefficients, same addressing
  always_ff @(posedge clk) begin
    if (wr_en) begin
      coef_mem[wr_addr] <= wr_coef;
    end
    rd_coef <= coef_mem[rd_addr];
  end

endmodule

@@ hw/rtl/pce_horner.sv @@
module pce_horner (
  input  logic              clk,
  input  logic              rst_n,
  input  pce_pkg::hrn_req_t req,
  output pce_pkg::hrn_rsp_t rsp
);
  import pce_pkg::*;

  logic               busy_r, busy_nxt;
  logic               add_ph_r, add_ph_nxt;
  logic [1:0]         step_r, step_nxt;
  logic               done_r, done_nxt;
  logic               sat_r, sat_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [32:0] d_r, d_nxt;
  coef_set_t          coef_r, coef_nxt;
  logic signed [64:0] prod_r, prod_nxt;

  logic signed [65:0] rnd_full;
  logic signed [49:0] rnd;
  logic signed [50:0] sum;
  logic signed [31:0] next_coef;
  logic               ovf;
  logic signed [31:0] sum_sat;

  // coefficient for the current step: quad, linear, then const
  always_comb begin
    case (step_r)
      2'd0:    next_coef = coef_r.c2;
      2'd1:    next_coef = coef_r.c1;
      default: next_coef = coef_r.c0;
    endcase
  end

  // round half up to Q16.16, add coefficient, saturate to 32 bits
  always_comb begin
    rnd_full = 66'(prod_r) + 66'sd32768;
    rnd      = rnd_full[65:16];
    sum      = 51'(rnd) + 51'(next_coef);
    ovf      = !((&sum[50:31]) || !(|sum[50:31]));
    if (ovf) begin
      sum_sat = sum[50] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end else begin
      sum_sat = sum[31:0];
    end
  end

  // step sequencing: multiply phase then add phase, three steps
  always_comb begin
    busy_nxt   = busy_r;
    add_ph_nxt = add_ph_r;
    step_nxt   = step_r;
    done_nxt   = 1'b0;
    sat_nxt    = sat_r;
    acc_nxt    = acc_r;
    d_nxt      = d_r;
    coef_nxt   = coef_r;
    prod_nxt   = prod_r;
    if (req.start) begin
      busy_nxt   = 1'b1;
      add_ph_nxt = 1'b0;
      step_nxt   = 2'd0;
      sat_nxt    = 1'b0;
      acc_nxt    = req.coef.c3;
      d_nxt      = req.d;
      coef_nxt   = req.coef;
    end else if (busy_r && !add_ph_r) begin
      prod_nxt   = acc_r * d_r;
      add_ph_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt    = sum_sat;
      sat_nxt    = sat_r | ovf;
      add_ph_nxt = 1'b0;
      if (step_r == 2'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      add_ph_r <= 1'b0;
      step_r   <= 2'd0;
      done_r   <= 1'b0;
      sat_r    <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      add_ph_r <= add_ph_nxt;
      step_r   <= step_nxt;
      done_r   <= done_nxt;
      sat_r    <= sat_nxt;
    end
    acc_r  <= acc_nxt;
    d_r    <= d_nxt;
    coef_r <= coef_nxt;
    prod_r <= prod_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.y    = acc_r;

endmodule

@@ verif/piecewise_cubic_evaluator_unit_tb.sv @@
module piecewise_cubic_evaluator_unit_tb;

  typedef enum logic {FN_LOAD = 1'b0, FN_EVAL = 1'b1} func_e;
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_SAT     = 2'd3
  } status_e;
  typedef enum {TS_NARROW, TS_MIXED, TS_WIDE} table_style_e;
  typedef enum {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    func_e              func;
    logic [5:0]         entry;
    logic signed [31:0] knot;
    logic signed [31:0] c0, c1, c2, c3;
    logic signed [31:0] xq;
  } spline_item_t;

  typedef struct packed {
    logic signed [31:0] y;
    status_e            st;
    logic [5:0]         seg;
  } spline_result_t;

  typedef struct {
    row_kind_e      kind;
    spline_item_t   item;
    bit             typed;
    spline_result_t known;
    int             cfg_val;
  } plan_row_t;

  localparam int TABLE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 2000;
  localparam int IDLE_PCT = 36;
  localparam int SETTLE_CYCLES = 80;   // longer than the longest evaluate with a full table
  localparam int STALL_LIMIT = 3000;
  localparam logic [1:0] REG_KNOTS_IN_USE = 2'd0;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_func = 1'b0;
  logic [5:0]         in_entry_index = '0;
  logic signed [31:0] in_knot_x = '0;
  logic signed [31:0] in_coef_const_in = '0;
  logic signed [31:0] in_coef_linear_in = '0;
  logic signed [31:0] in_coef_quad_in = '0;
  logic signed [31:0] in_coef_cubic_in = '0;
  logic signed [31:0] in_x_query = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_y_value;
  logic [1:0]         out_status;
  logic [5:0]         out_segment;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [1:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow of the segment table and the knot count register
  logic signed [31:0] knot_tab [TABLE_DEPTH];
  logic signed [31:0] c0_tab [TABLE_DEPTH];
  logic signed [31:0] c1_tab [TABLE_DEPTH];
  logic signed [31:0] c2_tab [TABLE_DEPTH];
  logic signed [31:0] c3_tab [TABLE_DEPTH];
  logic [6:0]         knots_cfg = '0;

  spline_result_t pending_values [$];
  plan_row_t      plan [$];
  spline_result_t head_value;
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int stall_cycles = 0;
  int status_hits [4] = '{0, 0, 0, 0};
  bit steady = 1'b0;

  piecewise_cubic_evaluator_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_entry_index    (in_entry_index),
    .in_knot_x         (in_knot_x),
    .in_coef_const_in  (in_coef_const_in),
    .in_coef_linear_in (in_coef_linear_in),
    .in_coef_quad_in   (in_coef_quad_in),
    .in_coef_cubic_in  (in_coef_cubic_in),
    .in_x_query        (in_x_query),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_y_value       (out_y_value),
    .out_status        (out_status),
    .out_segment       (out_segment),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #6 clk = ~clk;

  // Segment search and Horner evaluation in Q16.16, saturating each step
  function automatic spline_result_t spline_value(logic signed [31:0] xq);
    spline_result_t r;
    int n;
    int seg;
    longint d;
    longint acc;
    longint nxt [3];
    bit sat;
    r = '0;
    sat = 1'b0;
    n = (knots_cfg > TABLE_DEPTH) ? TABLE_DEPTH : knots_cfg;
    if (n == 0) begin
      r.st = ST_EMPTY;
      return r;
    end
    if (xq < knot_tab[0] || xq > knot_tab[n-1]) begin
      r.st = ST_OUTSIDE;
      return r;
    end
    seg = 0;
    for (int i = 0; i < n; i++)
      if (knot_tab[i] <= xq) seg = i;
    if (n >= 2 && seg > n - 2) seg = n - 2;
    d = longint'(xq) - longint'(knot_tab[seg]);
    acc = c3_tab[seg];
    nxt[0] = c2_tab[seg];
    nxt[1] = c1_tab[seg];
    nxt[2] = c0_tab[seg];
    for (int s = 0; s < 3; s++) begin
      // round half up: add 2^15, then floor by the arithmetic shift
      acc = ((acc * d + 32768) >>> 16) + nxt[s];
      if (acc > Q_MAX) begin
        acc = Q_MAX;
        sat = 1'b1;
      end else if (acc < Q_MIN) begin
        acc = Q_MIN;
        sat = 1'b1;
      end
    end
    r.y = acc[31:0];
    r.st = sat ? ST_SAT : ST_OK;
    r.seg = seg[5:0];
    return r;
  endfunction

  function automatic logic signed [31:0] rand_q(int bits);
    return $signed($urandom) >>> (32 - bits);
  endfunction

  function automatic logic signed [31:0] rand_coef(table_style_e style);
    return rand_q(style == TS_NARROW ? $urandom_range(4, 20) : $urandom_range(8, 32));
  endfunction

  // Directed rows
  function automatic void plan_load(int idx, logic signed [31:0] k, c0, c1, c2, c3);
    plan_row_t r;
    r.kind = ROW_ITEM;
    r.typed = 1'b0;
    r.known = '0;
    r.cfg_val = 0;
    r.item = '0;
    r.item.func = FN_LOAD;
    r.item.entry = idx[5:0];
    r.item.knot = k;
    r.item.c0 = c0;
    r.item.c1 = c1;
    r.item.c2 = c2;
    r.item.c3 = c3;
    plan.push_back(r);
  endfunction

  function automatic void plan_eval(logic signed [31:0] x, bit typed,
                                    logic signed [31:0] y, status_e st, int seg);
    plan_row_t r;
    r.kind = ROW_ITEM;
    r.typed = typed;
    r.cfg_val = 0;
    r.item = '0;
    r.item.func = FN_EVAL;
    r.item.xq = x;
    r.known.y = y;
    r.known.st = st;
    r.known.seg = seg[5:0];
    plan.push_back(r);
  endfunction

  function automatic void plan_cfg(int n);
    plan_row_t r;
    r.kind = ROW_CFG;
    r.item = '0;
    r.typed = 1'b0;
    r.known = '0;
    r.cfg_val = n;
    plan.push_back(r);
  endfunction

  // Present one item, wait for acceptance, update the shadow table or expect a result
  task automatic send_item(input spline_item_t it, input bit typed,
                           input spline_result_t known);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_func = it.func;
    in_entry_index = it.entry;
    in_knot_x = it.knot;
    in_coef_const_in = it.c0;
    in_coef_linear_in = it.c1;
    in_coef_quad_in = it.c2;
    in_coef_cubic_in = it.c3;
    in_x_query = it.xq;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (it.func == FN_LOAD) begin
      knot_tab[it.entry] = it.knot;
      c0_tab[it.entry] = it.c0;
      c1_tab[it.entry] = it.c1;
      c2_tab[it.entry] = it.c2;
      c3_tab[it.entry] = it.c3;
    end else begin
      pending_values.push_back(typed ? known : spline_value(it.xq));
    end
  endtask

  // Drain, let the block settle, write knots_in_use and read it back
  task automatic set_knots_in_use(input int n);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = REG_KNOTS_IN_USE;
    pwdata = n;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    knots_cfg = n[6:0];
    cfg_writes++;
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[6:0] !== n[6:0]) begin
      $display("%0t: knots_in_use readback expected %0d, got %0d",
               $time, n[6:0], prdata[6:0]);
      mismatches++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Fill entries 0..n_eff-1 with non-decreasing knots
  task automatic load_table(input int n_eff, input table_style_e style);
    spline_item_t it;
    longint kx;
    longint span;
    kx = rand_q(25);
    for (int i = 0; i < n_eff; i++) begin
      it.func = FN_LOAD;
      it.entry = i[5:0];
      it.xq = rand_q(32);
      it.c0 = rand_coef(style);
      it.c1 = rand_coef(style);
      it.c2 = rand_coef(style);
      it.c3 = rand_coef(style);
      if (style == TS_WIDE) begin
        span = 64'sd4294967296 / n_eff;
        it.knot = 32'(-64'sd2147483648 + longint'(i) * span + (longint'($urandom) % span));
      end else begin
        it.knot = kx[31:0];
        kx += $urandom_range(0, 1 << 20);
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  // Mostly evaluations aimed inside the knots, some reloads and strays
  task automatic send_random_item(input int n_eff, input table_style_e style);
    spline_item_t it;
    int pick;
    longint lo;
    longint hi;
    longint x;
    longint unsigned r64;
    it.entry = 6'($urandom_range(63));
    it.knot = rand_q(32);
    it.c0 = rand_coef(style);
    it.c1 = rand_coef(style);
    it.c2 = rand_coef(style);
    it.c3 = rand_coef(style);
    it.xq = rand_q(32);
    x = it.xq;
    if ($urandom_range(99) < 20) begin
      it.func = FN_LOAD;
      // usually keep the knot so the table stays ordered
      if ($urandom_range(99) < 85) it.knot = knot_tab[it.entry];
    end else begin
      it.func = FN_EVAL;
      if (n_eff > 0) begin
        lo = knot_tab[0];
        hi = knot_tab[n_eff-1];
        pick = $urandom_range(99);
        if (pick < 60 && lo <= hi) begin
          r64 = {$urandom, $urandom};
          x = lo + longint'(r64 % longint'(hi - lo + 1));
        end else if (pick < 80) begin
          x = longint'(knot_tab[$urandom_range(n_eff - 1)]) + int'($urandom_range(2)) - 1;
        end else if (pick < 90) begin
          x = (hi < Q_MAX) ? hi + 1 : lo - 1;
        end
        it.xq = x[31:0];
      end
    end
    send_item(it, 1'b0, '0);
  endtask

  // Result side: random back-pressure, none during the steady phase
  always @(negedge clk) out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      status_hits[out_status]++;
      if (pending_values.size() == 0) begin
        $display("%0t: result with nothing expected: y=%h status=%0d segment=%0d",
                 $time, out_y_value, out_status, out_segment);
        mismatches++;
      end else begin
        head_value = pending_values.pop_front();
        if (out_y_value !== head_value.y) begin
          $display("%0t: y_value expected %h, got %h", $time, head_value.y, out_y_value);
          mismatches++;
        end
        if (out_status !== head_value.st) begin
          $display("%0t: status expected %0d, got %0d", $time, head_value.st, out_status);
          mismatches++;
        end
        if (out_segment !== head_value.seg) begin
          $display("%0t: segment expected %0d, got %0d", $time, head_value.seg, out_segment);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: cycles in which nothing moves on any port
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: nothing accepted for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int n;
    int n_eff;
    int phase;
    int random_target;
    int directed_items;
    table_style_e style;
    plan_row_t row;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      knot_tab[i] = '0;
      c0_tab[i] = '0;
      c1_tab[i] = '0;
      c2_tab[i] = '0;
      c3_tab[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table after reset
    plan_eval(32'sd0, 1'b1, 32'sd0, ST_EMPTY, 0);
    plan_eval(32'sh8000_0000, 1'b1, 32'sd0, ST_EMPTY, 0);
    plan_eval(32'sh7FFF_FFFF, 1'b1, 32'sd0, ST_EMPTY, 0);
    // single knot: only its own position is inside
    plan_load(0, 32'sd0, 32'sh0001_0000, 32'sd0, 32'sd0, 32'sd0);
    plan_cfg(1);
    plan_eval(32'sd0, 1'b1, 32'sh0001_0000, ST_OK, 0);
    plan_eval(32'sd1, 1'b1, 32'sd0, ST_OUTSIDE, 0);
    plan_eval(-32'sd1, 1'b1, 32'sd0, ST_OUTSIDE, 0);
    // full-range knots with extreme coefficients, both saturation directions
    plan_load(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF);
    plan_load(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF);
    plan_cfg(2);
    plan_eval(32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, ST_SAT, 0);
    plan_eval(32'sh8000_0000, 1'b1, 32'sh7FFF_FFFF, ST_OK, 0);
    plan_load(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000);
    plan_eval(32'sh7FFF_FFFF, 1'b1, 32'sh8000_0000, ST_SAT, 0);
    plan_eval(32'sd0, 1'b0, 32'sd0, ST_OK, 0);
    // three knots (two segments): half-ulp rounding, exact knots, clamp to last segment
    plan_load(0, 32'sd0, 32'sd0, 32'sh0000_8000, 32'sd0, 32'sd0);
    plan_load(1, 32'sh0064_0000, 32'sh0001_8000, 32'shFFFF_4000, 32'sh0000_2000,
              32'shFFFF_F800);
    plan_load(2, 32'sh00C8_0000, 32'shFFF0_0000, 32'sh0000_0100, 32'shFFFF_FF00,
              32'sh0000_0040);
    plan_cfg(3);
    plan_eval(32'sd1, 1'b0, 32'sd0, ST_OK, 0);
    plan_eval(32'sh0064_0000, 1'b0, 32'sd0, ST_OK, 0);
    plan_eval(32'sh00C8_0000, 1'b0, 32'sd0, ST_OK, 0);
    // unsorted knots: clamped segment lies above x, so d goes negative
    plan_load(1, 32'sh012C_0000, 32'shFFFE_0000, 32'sh0003_0000, 32'shFFFF_C000,
              32'sh0000_0800);
    plan_eval(32'sh00C8_0000, 1'b0, 32'sd0, ST_OK, 0);
    plan_eval(32'sh0096_0000, 1'b0, 32'sd0, ST_OK, 0);
    plan_eval(-32'sh0000_8000, 1'b1, 32'sd0, ST_OUTSIDE, 0);
    plan_cfg(0);
    plan_eval(32'sh0096_0000, 1'b1, 32'sd0, ST_EMPTY, 0);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) set_knots_in_use(row.cfg_val);
      else send_item(row.item, row.typed, row.known);
    end
    directed_items = items_sent;

    // Random phases: new table, new knot count, then a burst of items
    random_target = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < random_target) begin
      if (phase == 0) begin
        n = TABLE_DEPTH;
      end else if (phase == 1) begin
        n = 100;   // above the table depth, counts as full
      end else begin
        n = $urandom_range(99);
        if (n < 5) n = 0;
        else if (n < 60) n = $urandom_range(1, 8);
        else if (n < 85) n = $urandom_range(9, 63);
        else if (n < 95) n = TABLE_DEPTH;
        else n = $urandom_range(65, 127);
      end
      style = (phase == 0) ? TS_WIDE : table_style_e'($urandom_range(2));
      n_eff = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
      steady = (phase == 3);
      load_table(n_eff, style);
      set_knots_in_use(n);
      repeat (steady ? 200 : $urandom_range(20, 120)) send_random_item(n_eff, style);
      phase++;
    end
    steady = 1'b0;

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d directed) over %0d knot-count settings, checked %0d results",
             items_sent, directed_items, cfg_writes, results_seen);
    $display("Status mix: ok %0d, empty %0d, outside %0d, saturated %0d",
             status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_OUTSIDE],
             status_hits[ST_SAT]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/pce_pkg.sv
hw/rtl/pce_table.sv
hw/rtl/pce_horner.sv
hw/rtl/piecewise_cubic_evaluator_unit.sv
verif/piecewise_cubic_evaluator_unit_tb.sv
